>>> hw/rtl/dstq_pkg.sv
package dstq_pkg;

	localparam int MAX_TASKS = 16;
	localparam int IDX_W     = $clog2(MAX_TASKS);
	localparam int CNT_W     = $clog2(MAX_TASKS + 1);
	localparam int WORD_W    = 32;
	localparam int STATUS_W  = 2;
	localparam int TOTAL_W   = 5;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_DELETE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

	typedef struct packed {
		logic [WORD_W-1:0] task_id;
		logic [WORD_W-1:0] deadline;
		logic [WORD_W-1:0] created;
	} dstq_entry_t;

	typedef struct packed {
		logic              mode;
		logic [WORD_W-1:0] task_id;
		logic [WORD_W-1:0] deadline;
		logic [WORD_W-1:0] created_at;
	} dstq_op_t;

	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		dstq_entry_t      wr_data;
	} dstq_mem_cmd_t;

	typedef struct packed {
		logic                valid;
		logic [STATUS_W-1:0] status;
		logic                head_valid;
		dstq_entry_t         head;
		logic [TOTAL_W-1:0]  entry_total;
	} dstq_res_t;

endpackage

>>> hw/rtl/dstq_req_if.sv
interface dstq_req_if import dstq_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              mode;
	logic [WORD_W-1:0] task_id;
	logic [WORD_W-1:0] deadline;
	logic [WORD_W-1:0] created_at;

	modport source (output valid, output mode, output task_id, output deadline,
		output created_at, input ready);
	modport sink (input valid, input mode, input task_id, input deadline,
		input created_at, output ready);
endinterface

>>> hw/rtl/dstq_rsp_if.sv
interface dstq_rsp_if import dstq_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic                head_valid;
	logic [WORD_W-1:0]   head_task_id;
	logic [WORD_W-1:0]   head_deadline;
	logic [WORD_W-1:0]   head_created_at;
	logic [TOTAL_W-1:0]  entry_total;

	modport source (output valid, output status, output head_valid, output head_task_id,
		output head_deadline, output head_created_at, output entry_total, input ready);
	modport sink (input valid, input status, input head_valid, input head_task_id,
		input head_deadline, input head_created_at, input entry_total, output ready);
endinterface

>>> hw/rtl/dstq_mem.sv
module dstq_mem import dstq_pkg::*; (
	input  logic          clk,
	input  dstq_mem_cmd_t cmd,
	output dstq_entry_t   rd_data
);

	dstq_entry_t mem [MAX_TASKS];

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[cmd.wr_addr] <= cmd.wr_data;
		end
		if (cmd.rd_en) begin
			rd_data <= mem[cmd.rd_addr];
		end
	end

endmodule

>>> hw/rtl/dstq_seq.sv
module dstq_seq import dstq_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	dstq_req_if.sink       req,
	output dstq_res_t      res,
	input  logic           res_ready,
	output dstq_mem_cmd_t  mem_cmd,
	input  dstq_entry_t    rd_data
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_START = 7'b0000010,
		S_ICMP  = 7'b0000100,
		S_IPUT  = 7'b0001000,
		S_DCMP  = 7'b0010000,
		S_HRD   = 7'b0100000,
		S_RES   = 7'b1000000
	} state_t;

	state_t              state_q, state_d;
	logic [CNT_W-1:0]    k_q, k_d;
	logic [CNT_W-1:0]    cnt_q, cnt_d;
	logic                found_q, found_d;
	logic [STATUS_W-1:0] status_q, status_d;
	dstq_op_t            op_q;

	dstq_entry_t         new_entry;
	logic [WORD_W-1:0]   cmp_key, cmp_ref;
	logic                cmp_eq, cmp_gt;
	logic [CNT_W-1:0]    cnt_m1, k_m1, k_m2, k_p1;
	logic                accept;

	assign accept    = req.valid && req.ready;
	assign new_entry = '{task_id: op_q.task_id, deadline: op_q.deadline,
		created: op_q.created_at};

	// shared comparator: deadline order on insert, id match on delete
	assign cmp_key = (op_q.mode == MODE_DELETE) ? rd_data.task_id : rd_data.deadline;
	assign cmp_ref = (op_q.mode == MODE_DELETE) ? op_q.task_id : op_q.deadline;
	assign cmp_eq  = (cmp_key == cmp_ref);
	assign cmp_gt  = (cmp_key > cmp_ref);

	assign cnt_m1 = cnt_q - CNT_W'(1);
	assign k_m1   = k_q - CNT_W'(1);
	assign k_m2   = k_q - CNT_W'(2);
	assign k_p1   = k_q + CNT_W'(1);

	always_comb begin
		state_d   = state_q;
		k_d       = k_q;
		cnt_d     = cnt_q;
		found_d   = found_q;
		status_d  = status_q;
		mem_cmd   = '0;
		req.ready = (state_q == S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					state_d  = S_START;
					found_d  = 1'b0;
					status_d = ST_DONE;
				end
			end
			S_START: begin
				if (op_q.mode == MODE_INSERT) begin
					if (cnt_q == CNT_W'(MAX_TASKS)) begin
						status_d = ST_FULL;
						state_d  = S_HRD;
					end else if (cnt_q == '0) begin
						k_d     = '0;
						state_d = S_IPUT;
					end else begin
						k_d             = cnt_q;
						mem_cmd.rd_en   = 1'b1;
						mem_cmd.rd_addr = cnt_m1[IDX_W-1:0];
						state_d         = S_ICMP;
					end
				end else begin
					if (cnt_q == '0) begin
						status_d = ST_NOT_FOUND;
						state_d  = S_HRD;
					end else begin
						k_d             = '0;
						mem_cmd.rd_en   = 1'b1;
						mem_cmd.rd_addr = '0;
						state_d         = S_DCMP;
					end
				end
			end
			S_ICMP: begin
				// walk from the tail, move later deadlines up one slot
				mem_cmd.wr_en   = 1'b1;
				mem_cmd.wr_addr = k_q[IDX_W-1:0];
				if (cmp_gt) begin
					mem_cmd.wr_data = rd_data;
					k_d             = k_m1;
					if (k_m1 == '0) begin
						state_d = S_IPUT;
					end else begin
						mem_cmd.rd_en   = 1'b1;
						mem_cmd.rd_addr = k_m2[IDX_W-1:0];
					end
				end else begin
					mem_cmd.wr_data = new_entry;
					cnt_d           = cnt_q + CNT_W'(1);
					state_d         = S_HRD;
				end
			end
			S_IPUT: begin
				mem_cmd.wr_en   = 1'b1;
				mem_cmd.wr_addr = k_q[IDX_W-1:0];
				mem_cmd.wr_data = new_entry;
				cnt_d           = cnt_q + CNT_W'(1);
				state_d         = S_HRD;
			end
			S_DCMP: begin
				// after the match, pull each entry down one slot
				if (found_q) begin
					mem_cmd.wr_en   = 1'b1;
					mem_cmd.wr_addr = k_m1[IDX_W-1:0];
					mem_cmd.wr_data = rd_data;
				end
				found_d = found_q | cmp_eq;
				if (k_p1 < cnt_q) begin
					mem_cmd.rd_en   = 1'b1;
					mem_cmd.rd_addr = k_p1[IDX_W-1:0];
					k_d             = k_p1;
				end else begin
					if (found_q || cmp_eq) begin
						cnt_d = cnt_m1;
					end else begin
						status_d = ST_NOT_FOUND;
					end
					state_d = S_HRD;
				end
			end
			S_HRD: begin
				mem_cmd.rd_en   = (cnt_q != '0);
				mem_cmd.rd_addr = '0;
				state_d         = S_RES;
			end
			S_RES: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		res.valid       = (state_q == S_RES);
		res.status      = status_q;
		res.head_valid  = (cnt_q != '0);
		res.head        = (cnt_q != '0) ? rd_data : '0;
		res.entry_total = TOTAL_W'(cnt_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			k_q      <= '0;
			cnt_q    <= '0;
			found_q  <= 1'b0;
			status_q <= ST_DONE;
		end else begin
			state_q  <= state_d;
			k_q      <= k_d;
			cnt_q    <= cnt_d;
			found_q  <= found_d;
			status_q <= status_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= '{mode: req.mode, task_id: req.task_id, deadline: req.deadline,
				created_at: req.created_at};
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_TASKS))
		else $error("entry count above capacity");

	a_icmp_slot: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ICMP |-> (k_q != '0 && k_q <= cnt_q))
		else $error("insert scan slot out of range");

	a_dcmp_slot: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DCMP |-> k_q < cnt_q)
		else $error("delete scan slot out of range");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RES && status_q == ST_FULL) |-> cnt_q == CNT_W'(MAX_TASKS))
		else $error("full status with free slots");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RES && res_ready) |=> (state_q == S_IDLE && $stable(cnt_q)))
		else $error("count changed outside a request");

endmodule

>>> hw/rtl/deadline_sorted_task_queue.sv
// Earliest-deadline-first task queue of up to MAX_TASKS (16) entries kept in
// ascending deadline order; equal deadlines keep arrival order. Each request
// either inserts a task (dropped with status full when all slots are taken) or
// removes the first task with a matching id (status not found when absent),
// and returns one response with the status, the head task and the task count.
// One entry memory with a read port and a write port and one shared comparator
// do all the work, one entry per cycle: an insert walks from the tail over the
// entries with a later deadline, and a delete walks over every task held.
// The request channel is ready only while no request is in progress; the
// response sits in an output register, so the next request is taken while it
// waits to be read.
module deadline_sorted_task_queue import dstq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	dstq_req_if.sink  req,
	dstq_rsp_if.source rsp
);

	dstq_res_t     res;
	logic          res_ready;
	dstq_mem_cmd_t mem_cmd;
	dstq_entry_t   rd_data;

	logic          out_valid_q;
	dstq_res_t     out_q;

	dstq_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.res       (res),
		.res_ready (res_ready),
		.mem_cmd   (mem_cmd),
		.rd_data   (rd_data)
	);

	dstq_mem u_mem (
		.clk     (clk),
		.cmd     (mem_cmd),
		.rd_data (rd_data)
	);

	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res.valid) begin
			out_q <= res;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.status          = out_q.status;
	assign rsp.head_valid      = out_q.head_valid;
	assign rsp.head_task_id    = out_q.head.task_id;
	assign rsp.head_deadline   = out_q.head.deadline;
	assign rsp.head_created_at = out_q.head.created;
	assign rsp.entry_total     = out_q.entry_total;

endmodule

>>> bench/tb_deadline_sorted_task_queue.sv
`timescale 1ns / 1ps

module tb_deadline_sorted_task_queue;
	import dstq_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 3000;
	localparam int unsigned SINK_HOLD_CYCLES = 400;
	localparam int unsigned SETTLE_CYCLES = 60;
	localparam int unsigned IDLE_PCT = 21;

	logic clk;
	logic arst_n;

	dstq_req_if req();
	dstq_rsp_if rsp();

	deadline_sorted_task_queue i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	dstq_entry_t edf_entries[MAX_TASKS];
	int unsigned edf_count;
	dstq_res_t   predicted_replies[$];
	dstq_res_t   reply_want;
	int unsigned errors;
	int unsigned quiet_cycles;
	logic        steady;
	logic        sink_hold_request;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic dstq_res_t edf_apply(input dstq_op_t op);
		dstq_res_t r;
		int unsigned pos;
		int unsigned k;
		r = '0;
		r.valid = 1'b1;
		pos = 0;
		if (op.mode == MODE_INSERT) begin
			if (edf_count >= MAX_TASKS) begin
				r.status = ST_FULL;
			end else begin
				while (pos < edf_count && edf_entries[pos].deadline <= op.deadline) pos++;
				for (k = edf_count; k > pos; k--) edf_entries[k] = edf_entries[k - 1];
				edf_entries[pos].task_id = op.task_id;
				edf_entries[pos].deadline = op.deadline;
				edf_entries[pos].created = op.created_at;
				edf_count++;
				r.status = ST_DONE;
			end
		end else begin
			while (pos < edf_count && edf_entries[pos].task_id != op.task_id) pos++;
			if (pos >= edf_count) begin
				r.status = ST_NOT_FOUND;
			end else begin
				for (k = pos; k + 1 < edf_count; k++) edf_entries[k] = edf_entries[k + 1];
				edf_count--;
				r.status = ST_DONE;
			end
		end
		if (edf_count != 0) begin
			r.head_valid = 1'b1;
			r.head = edf_entries[0];
		end
		r.entry_total = edf_count[TOTAL_W-1:0];
		return r;
	endfunction

	function automatic dstq_op_t make_op(input logic mode, input logic [WORD_W-1:0] id,
		input logic [WORD_W-1:0] dl, input logic [WORD_W-1:0] ct);
		dstq_op_t op;
		op.mode = mode;
		op.task_id = id;
		op.deadline = dl;
		op.created_at = ct;
		return op;
	endfunction

	function automatic dstq_op_t random_request(input int unsigned insert_pct);
		dstq_op_t op;
		op.mode = ($urandom_range(99) < insert_pct) ? MODE_INSERT : MODE_DELETE;
		op.created_at = $urandom;
		case ($urandom_range(3))
			0, 1: begin
				op.deadline = $urandom_range(15);
			end
			2: begin
				op.deadline = $urandom;
			end
			default: begin
				op.deadline = 32'hFFFF_FFFF - $urandom_range(15);
			end
		endcase
		if (op.mode == MODE_DELETE && edf_count != 0 && $urandom_range(99) < 70)
			op.task_id = edf_entries[$urandom_range(edf_count - 1)].task_id;
		else if ($urandom_range(99) < 40)
			op.task_id = $urandom_range(7);
		else
			op.task_id = $urandom;
		return op;
	endfunction

	task automatic send_request(input dstq_op_t op);
		if (!steady && $urandom_range(99) < IDLE_PCT) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.mode <= op.mode;
		req.task_id <= op.task_id;
		req.deadline <= op.deadline;
		req.created_at <= op.created_at;
		do @(posedge clk); while (!req.ready);
		predicted_replies.push_back(edf_apply(op));
	endtask

	task automatic test_empty_queue();
		send_request(make_op(MODE_DELETE, 32'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
	endtask

	task automatic test_order_and_extremes();
		send_request(make_op(MODE_INSERT, 32'd0, 32'hFFFF_FFFF, 32'd0));
		send_request(make_op(MODE_INSERT, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF));
		send_request(make_op(MODE_INSERT, 32'd7, 32'd100, 32'd1));
		send_request(make_op(MODE_INSERT, 32'd8, 32'd100, 32'd2));
		send_request(make_op(MODE_INSERT, 32'd7, 32'd50, 32'd3));
		send_request(make_op(MODE_DELETE, 32'd7, 32'd0, 32'd0));
		send_request(make_op(MODE_DELETE, 32'd1234, 32'd0, 32'd0));
		send_request(make_op(MODE_DELETE, 32'hFFFF_FFFF, 32'd0, 32'd0));
		send_request(make_op(MODE_INSERT, 32'd9, 32'hFFFF_FFFF, 32'd5));
	endtask

	task automatic test_full_queue();
		int unsigned k;
		k = 0;
		while (edf_count < MAX_TASKS) begin
			send_request(make_op(MODE_INSERT, 32'd100 + k, k * 37, ~k));
			k++;
		end
		send_request(make_op(MODE_INSERT, 32'hA5A5_5A5A, 32'd1, 32'd1));
		send_request(make_op(MODE_DELETE, 32'd8, 32'd0, 32'd0));
	endtask

	task automatic test_receiver_backpressure();
		int unsigned i;
		sink_hold_request = 1'b1;
		for (i = 0; i < 40; i++) send_request(random_request(50));
	endtask

	task automatic test_sender_pause();
		int unsigned i;
		for (i = 0; i < 10; i++) send_request(random_request(60));
		req.valid <= 1'b0;
		while (predicted_replies.size() != 0) @(posedge clk);
		for (i = 0; i < 10; i++) send_request(random_request(40));
	endtask

	task automatic test_random_mix(input int unsigned n_items);
		int unsigned i;
		for (i = 0; i < n_items; i++) begin
			steady = (i >= 500 && i < 800);
			send_request(random_request(((i / 120) % 2 == 0) ? 75 : 25));
		end
		steady = 1'b0;
	endtask

	initial begin : drive_reply_ready
		int unsigned hold_left;
		hold_left = 0;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (sink_hold_request) begin
				sink_hold_request = 1'b0;
				hold_left = SINK_HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	function automatic void check_field(input string name, input logic [WORD_W-1:0] want,
		input logic [WORD_W-1:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			if (predicted_replies.size() == 0) begin
				errors++;
				$display("%0t: unexpected reply status %0d total %0d", $time, rsp.status,
					rsp.entry_total);
			end else begin
				reply_want = predicted_replies.pop_front();
				check_field("status", WORD_W'(reply_want.status), WORD_W'(rsp.status));
				check_field("head_valid", WORD_W'(reply_want.head_valid),
					WORD_W'(rsp.head_valid));
				check_field("head_task_id", reply_want.head.task_id, rsp.head_task_id);
				check_field("head_deadline", reply_want.head.deadline, rsp.head_deadline);
				check_field("head_created_at", reply_want.head.created,
					rsp.head_created_at);
				check_field("entry_total", WORD_W'(reply_want.entry_total),
					WORD_W'(rsp.entry_total));
			end
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		errors = 0;
		edf_count = 0;
		steady = 1'b0;
		sink_hold_request = 1'b0;
		quiet_cycles <= 0;
		arst_n <= 1'b0;
		req.valid <= 1'b0;
		req.mode <= MODE_INSERT;
		req.task_id <= '0;
		req.deadline <= '0;
		req.created_at <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_queue();
		test_order_and_extremes();
		test_full_queue();
		test_receiver_backpressure();
		test_sender_pause();
		test_random_mix(1560);
		req.valid <= 1'b0;
		while (predicted_replies.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
